// ===== design/ffha_pkg.sv =====
// Shared types, codes and constants of the first-fit heap allocator.
`timescale 1ns / 1ps
package ffha_pkg;

  // Parameter defaults
  localparam int POOL_BYTES_DEF   = 16384;
  localparam int HEADER_BYTES_DEF = 4;
  localparam int POOL_COUNT_DEF   = 2;

  // Fixed field widths
  localparam int CMD_W     = 3;
  localparam int REQ_W     = 15;
  localparam int FOFF_W    = 14;
  localparam int CFG_W     = 15;
  localparam int CFG_IDX_W = 2;
  localparam int ST_W      = 2;
  localparam int CNT_W     = 13;
  localparam int TOT_W     = 15;
  localparam int PCT_W     = 7;
  localparam int PCT_FULL  = 100;

  // Alignment masks for request rounding
  localparam logic [REQ_W-1:0] ALIGN4_MASK = REQ_W'(3);
  localparam logic [REQ_W-1:0] ALIGN8_MASK = REQ_W'(7);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_POOL0_BYTES   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POOL1_BYTES   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ALIGN_EIGHT   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MERGE_ON_FREE = 2'd3;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_INIT    = 3'd0;
  localparam logic [CMD_W-1:0] CMD_ALLOC   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_FREE    = 3'd2;
  localparam logic [CMD_W-1:0] CMD_DEFRAG  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_MONITOR = 3'd4;

  typedef enum logic [ST_W-1:0] {
    ST_DONE    = 2'd0,
    ST_NOFIT   = 2'd1,
    ST_IGNORED = 2'd2
  } res_status_t;

  // Datapath operations issued by the controller
  typedef enum logic [4:0] {
    OP_NONE,
    OP_LATCH,
    OP_TOKEN,
    OP_INIT,
    OP_READ_OFF,
    OP_ADV,
    OP_NOFIT,
    OP_SPLIT,
    OP_TAKE_SIZE,
    OP_TAKE_WHOLE,
    OP_FREE_WR,
    OP_AB_START,
    OP_READ_NXT,
    OP_AB_ADD,
    OP_AB_WRITE,
    OP_ADV_CUR,
    OP_DONE,
    OP_ACC,
    OP_DIV_USED,
    OP_UPCT,
    OP_DIV_FRAG,
    OP_FPCT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   publish;
  } ctl_cmd_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             zero_req;
    logic             bad;
    logic             pool_ready;
    logic             handle_void;
    logic             merge_en;
    logic             hdr_used;
    logic             fits;
    logic             can_split;
    logic             match;
    logic             nxt_ok_hdr;
    logic             nxt_ok_cur;
    logic             ft_nz;
    logic             div_done;
  } dp_sts_t;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic              pool_index;
    logic [REQ_W-1:0]  request_size;
    logic [FOFF_W-1:0] free_offset;
    logic              free_is_token;
    logic              free_is_null;
  } in_item_t;

  typedef struct packed {
    res_status_t       status;
    logic [FOFF_W-1:0] data_offset;
    logic              zero_token;
    logic [CNT_W-1:0]  free_count;
    logic [CNT_W-1:0]  used_count;
    logic [TOT_W-1:0]  free_total;
    logic [TOT_W-1:0]  free_largest;
    logic [PCT_W-1:0]  used_percent;
    logic [PCT_W-1:0]  frag_percent;
  } res_item_t;

endpackage

// ===== design/ffha_if.sv =====
// Valid/ready channel interfaces for commands and results.
`timescale 1ns / 1ps
interface ffha_in_if;
  import ffha_pkg::*;
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic              pool_index;
  logic [REQ_W-1:0]  request_size;
  logic [FOFF_W-1:0] free_offset;
  logic              free_is_token;
  logic              free_is_null;
  modport source (output valid, command, pool_index, request_size, free_offset,
                  free_is_token, free_is_null, input ready);
  modport sink (input valid, command, pool_index, request_size, free_offset,
                free_is_token, free_is_null, output ready);
endinterface

interface ffha_out_if;
  import ffha_pkg::*;
  logic              valid;
  logic              ready;
  logic [ST_W-1:0]   status;
  logic [FOFF_W-1:0] data_offset;
  logic              zero_token;
  logic [CNT_W-1:0]  free_count;
  logic [CNT_W-1:0]  used_count;
  logic [TOT_W-1:0]  free_total;
  logic [TOT_W-1:0]  free_largest;
  logic [PCT_W-1:0]  used_percent;
  logic [PCT_W-1:0]  frag_percent;
  modport source (output valid, status, data_offset, zero_token, free_count, used_count,
                  free_total, free_largest, used_percent, frag_percent, input ready);
  modport sink (input valid, status, data_offset, zero_token, free_count, used_count,
                free_total, free_largest, used_percent, frag_percent, output ready);
endinterface

// ===== design/ffha_div.sv =====
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module ffha_div #(
  parameter int DVW = 23,
  parameter int DSW = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [DVW-1:0] dividend,
  input  logic [DSW-1:0] divisor,
  output logic           done,
  output logic [DVW-1:0] quotient
);
  localparam int CTW = $clog2(DVW + 1);

  logic [DSW-1:0] rem_r, rem_nxt;
  logic [DVW-1:0] quo_r, quo_nxt;
  logic [DSW-1:0] dsr_r;
  logic [CTW-1:0] cnt_r, cnt_nxt;
  logic           done_r, done_nxt;
  logic [DSW:0]   shifted;
  logic [DSW:0]   diff;

  // Trial subtract of the shifted remainder
  always_comb begin
    shifted = {rem_r, quo_r[DVW-1]};
    diff    = shifted - {1'b0, dsr_r};
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    cnt_nxt = cnt_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt = '0;
      quo_nxt = dividend;
      cnt_nxt = CTW'(DVW);
    end else if (cnt_r != '0) begin
      rem_nxt = diff[DSW] ? shifted[DSW-1:0] : diff[DSW-1:0];
      quo_nxt = {quo_r[DVW-2:0], ~diff[DSW]};
      cnt_nxt = cnt_r - CTW'(1);
      done_nxt = (cnt_r == CTW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    if (start) begin
      dsr_r <= divisor;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ===== design/ffha_dp.sv =====
// Datapath: configuration, header memory, chain walk registers and statistics.
`timescale 1ns / 1ps
module ffha_dp #(
  parameter int POOL_BYTES   = ffha_pkg::POOL_BYTES_DEF,
  parameter int HEADER_BYTES = ffha_pkg::HEADER_BYTES_DEF,
  parameter int POOL_COUNT   = ffha_pkg::POOL_COUNT_DEF,
  parameter int DVW          = 25,
  parameter int DSW          = 17
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [ffha_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ffha_pkg::CFG_W-1:0]     cfg_data,
  input  ffha_pkg::in_item_t             in_item,
  input  ffha_pkg::ctl_cmd_t             ctl,
  output ffha_pkg::dp_sts_t              sts,
  output ffha_pkg::res_item_t            res,
  output logic                          div_start,
  output logic [DVW-1:0]                div_dividend,
  output logic [DSW-1:0]                div_divisor,
  input  logic                          div_done,
  input  logic [DVW-1:0]                div_quotient
);
  import ffha_pkg::*;

  localparam int WORDS = POOL_BYTES / 4;
  localparam int DEPTH = POOL_COUNT * WORDS;
  localparam int AW    = $clog2(DEPTH);
  localparam int WIW   = $clog2(WORDS);
  localparam int SZW   = $clog2(POOL_BYTES + 1);
  localparam int OW    = SZW + 2;
  localparam int HW    = SZW + 1;
  localparam int PW    = (POOL_COUNT > 1) ? $clog2(POOL_COUNT) : 1;
  localparam int RW    = REQ_W + 1;
  localparam int CMPW  = (OW > RW) ? OW : RW;
  localparam int EW    = $clog2(WORDS + 2);

  // Configuration registers
  logic [CFG_W-1:0] pool0_bytes_r, pool1_bytes_r;
  logic             align_eight_r, merge_on_free_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool0_bytes_r   <= CFG_W'(16384);
      pool1_bytes_r   <= CFG_W'(16384);
      align_eight_r   <= 1'b0;
      merge_on_free_r <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_POOL0_BYTES:   pool0_bytes_r   <= cfg_data;
        REG_POOL1_BYTES:   pool1_bytes_r   <= cfg_data;
        REG_ALIGN_EIGHT:   align_eight_r   <= cfg_data[0];
        REG_MERGE_ON_FREE: merge_on_free_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Header memory and working registers
  logic [HW-1:0]  hdr_mem [DEPTH];
  logic [HW-1:0]  rdata_r;
  in_item_t       item_r;
  logic [SZW-1:0] total_r [POOL_COUNT];
  logic           ready_r [POOL_COUNT];
  logic [OW-1:0]  off_r, base_r;
  logic [SZW-1:0] cur_r;
  logic [EW-1:0]  fc_r, uc_r;
  logic [OW-1:0]  ft_r;
  logic [SZW-1:0] fl_r;
  res_item_t      work_r, res_r;

  // Decode of the latched item
  logic [PW-1:0]    pi;
  logic             pool_ok;
  logic [SZW-1:0]   cur_total;
  logic [AW-1:0]    pool_base;
  logic [REQ_W-1:0] amask;
  logic [RW-1:0]    size_rnd;
  logic [SZW-1:0]   hsz;
  logic [OW-1:0]    n_hdr, n_cur, dat_off;
  logic [CMPW-1:0]  split_off;
  logic [CFG_W-1:0] t_raw;
  logic [SZW-1:0]   t_clamp;

  assign pi        = PW'(item_r.pool_index);
  assign pool_ok   = 32'(item_r.pool_index) < 32'(POOL_COUNT);
  assign cur_total = pool_ok ? total_r[pi] : '0;
  assign pool_base = AW'(item_r.pool_index) * AW'(WORDS);
  assign amask     = align_eight_r ? ALIGN8_MASK : ALIGN4_MASK;
  assign hsz       = rdata_r[SZW-1:0];
  assign n_hdr     = off_r + OW'(HEADER_BYTES) + OW'(hsz);
  assign n_cur     = base_r + OW'(HEADER_BYTES) + OW'(cur_r);
  assign dat_off   = off_r + OW'(HEADER_BYTES);
  assign split_off = CMPW'(dat_off) + CMPW'(size_rnd);

  // Round the request up to the alignment
  always_comb begin
    if ((item_r.request_size & amask) != '0) begin
      size_rnd = RW'(item_r.request_size & ~amask) + RW'(amask) + RW'(1);
    end else begin
      size_rnd = RW'(item_r.request_size);
    end
  end

  // Saturate the configured pool size
  always_comb begin
    t_raw = item_r.pool_index ? pool1_bytes_r : pool0_bytes_r;
    if (32'(t_raw) > 32'(POOL_BYTES)) begin
      t_clamp = SZW'(POOL_BYTES);
    end else if (32'(t_raw) < 32'(HEADER_BYTES)) begin
      t_clamp = SZW'(HEADER_BYTES);
    end else begin
      t_clamp = SZW'(t_raw);
    end
  end

  function automatic logic [AW-1:0] word_addr(input logic [AW-1:0] pb,
                                               input logic [OW-1:0] off);
    word_addr = pb + AW'(off[WIW+1:2]);
  endfunction

  // Status towards the controller
  always_comb begin
    sts.cmd         = item_r.command;
    sts.zero_req    = (item_r.command == CMD_ALLOC) && (item_r.request_size == '0);
    sts.bad         = (item_r.command > CMD_MONITOR) || !pool_ok;
    sts.pool_ready  = pool_ok && ready_r[pi];
    sts.handle_void = item_r.free_is_token || item_r.free_is_null;
    sts.merge_en    = merge_on_free_r;
    sts.hdr_used    = rdata_r[HW-1];
    sts.fits        = CMPW'(hsz) >= CMPW'(size_rnd);
    sts.can_split   = (CMPW'(hsz) - CMPW'(size_rnd)) > CMPW'(HEADER_BYTES);
    sts.match       = CMPW'(dat_off) == CMPW'(item_r.free_offset);
    sts.nxt_ok_hdr  = (n_hdr + OW'(HEADER_BYTES)) < OW'(cur_total);
    sts.nxt_ok_cur  = (n_cur + OW'(HEADER_BYTES)) < OW'(cur_total);
    sts.ft_nz       = ft_r != '0;
    sts.div_done    = div_done;
  end

  // Memory port selection
  logic          mem_we, mem_re;
  logic [AW-1:0] waddr, raddr;
  logic [HW-1:0] wdata;

  always_comb begin
    mem_we = 1'b0;
    mem_re = 1'b0;
    waddr  = word_addr(pool_base, off_r);
    raddr  = word_addr(pool_base, off_r);
    wdata  = '0;
    case (ctl.op)
      OP_INIT: begin
        mem_we = 1'b1;
        waddr  = pool_base;
        wdata  = {1'b0, t_clamp - SZW'(HEADER_BYTES)};
      end
      OP_READ_OFF: mem_re = 1'b1;
      OP_READ_NXT: begin
        mem_re = 1'b1;
        raddr  = word_addr(pool_base, n_cur);
      end
      OP_SPLIT: begin
        mem_we = 1'b1;
        waddr  = word_addr(pool_base, OW'(split_off));
        wdata  = {1'b0, SZW'(CMPW'(hsz) - CMPW'(size_rnd) - CMPW'(HEADER_BYTES))};
      end
      OP_TAKE_SIZE: begin
        mem_we = 1'b1;
        wdata  = {1'b1, SZW'(size_rnd)};
      end
      OP_TAKE_WHOLE: begin
        mem_we = 1'b1;
        wdata  = {1'b1, hsz};
      end
      OP_FREE_WR: begin
        mem_we = 1'b1;
        wdata  = {1'b0, hsz};
      end
      OP_AB_WRITE: begin
        mem_we = 1'b1;
        waddr  = word_addr(pool_base, base_r);
        wdata  = {1'b0, cur_r};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      hdr_mem[waddr] <= wdata;
    end
    if (mem_re) begin
      rdata_r <= hdr_mem[raddr];
    end
  end

  // Divider operands
  assign div_start    = (ctl.op == OP_DIV_USED) || (ctl.op == OP_DIV_FRAG);
  assign div_dividend = (ctl.op == OP_DIV_USED) ? DVW'(ft_r) * DVW'(PCT_FULL)
                                                : DVW'(fl_r) * DVW'(PCT_FULL);
  assign div_divisor  = (ctl.op == OP_DIV_USED) ? DSW'(cur_total) : DSW'(ft_r);

  // Pool bookkeeping
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < POOL_COUNT; i++) begin
        ready_r[i] <= 1'b0;
      end
    end else if (ctl.op == OP_INIT) begin
      ready_r[pi] <= 1'b1;
    end
    if (ctl.op == OP_INIT) begin
      total_r[pi] <= t_clamp;
    end
  end

  // Walk registers, statistics and result
  always_ff @(posedge clk) begin
    case (ctl.op)
      OP_LATCH: begin
        item_r <= in_item;
        off_r  <= '0;
        fc_r   <= '0;
        uc_r   <= '0;
        ft_r   <= '0;
        fl_r   <= '0;
        work_r <= '{status: ST_IGNORED, default: '0};
      end
      OP_TOKEN: begin
        work_r.status     <= ST_DONE;
        work_r.zero_token <= 1'b1;
      end
      OP_INIT, OP_FREE_WR, OP_DONE: work_r.status <= ST_DONE;
      OP_ADV: off_r <= n_hdr;
      OP_NOFIT: work_r.status <= ST_NOFIT;
      OP_TAKE_SIZE, OP_TAKE_WHOLE: begin
        work_r.status      <= ST_DONE;
        work_r.data_offset <= FOFF_W'(dat_off);
      end
      OP_AB_START: begin
        base_r <= off_r;
        cur_r  <= hsz;
      end
      OP_AB_ADD: cur_r <= cur_r + hsz + SZW'(HEADER_BYTES);
      OP_AB_WRITE: off_r <= base_r;
      OP_ADV_CUR: off_r <= n_cur;
      OP_ACC: begin
        off_r <= n_hdr;
        if (rdata_r[HW-1]) begin
          uc_r <= uc_r + EW'(1);
        end else begin
          fc_r <= fc_r + EW'(1);
          ft_r <= ft_r + OW'(hsz);
          if (hsz > fl_r) begin
            fl_r <= hsz;
          end
        end
      end
      OP_UPCT: begin
        work_r.status       <= ST_DONE;
        work_r.free_count   <= CNT_W'(fc_r);
        work_r.used_count   <= CNT_W'(uc_r);
        work_r.free_total   <= TOT_W'(ft_r);
        work_r.free_largest <= TOT_W'(fl_r);
        work_r.used_percent <= PCT_W'(PCT_FULL) - PCT_W'(div_quotient);
      end
      OP_FPCT: work_r.frag_percent <= PCT_W'(PCT_FULL) - PCT_W'(div_quotient);
      default: ;
    endcase
    if (ctl.publish) begin
      res_r <= work_r;
    end
  end

  assign res = res_r;

endmodule

// ===== design/ffha_ctrl.sv =====
// Controller: sequences each command over the datapath and runs the handshakes.
`timescale 1ns / 1ps
module ffha_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  ffha_pkg::dp_sts_t  sts,
  output ffha_pkg::ctl_cmd_t ctl
);
  import ffha_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DEC,
    S_RD,
    S_EV,
    S_TAKE,
    S_AB_CHK,
    S_AB_EV,
    S_AB_END,
    S_DIV1,
    S_DW1,
    S_DIV2,
    S_DW2,
    S_RESP
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  // Next state and datapath operation
  always_comb begin
    state_nxt   = state_r;
    ctl.op      = OP_NONE;
    ctl.publish = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          ctl.op    = OP_LATCH;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        state_nxt = S_RESP;
        if (sts.zero_req) begin
          ctl.op = OP_TOKEN;
        end else if (sts.bad) begin
          ctl.op = OP_NONE;
        end else if (sts.cmd == CMD_INIT) begin
          ctl.op = OP_INIT;
        end else if (!sts.pool_ready) begin
          ctl.op = OP_NONE;
        end else if (sts.cmd == CMD_FREE && sts.handle_void) begin
          ctl.op = OP_NONE;
        end else begin
          ctl.op    = OP_READ_OFF;
          state_nxt = S_EV;
        end
      end
      S_RD: begin
        ctl.op    = OP_READ_OFF;
        state_nxt = S_EV;
      end
      S_EV: begin
        case (sts.cmd)
          CMD_ALLOC: begin
            if (!sts.hdr_used && sts.fits) begin
              ctl.op    = sts.can_split ? OP_SPLIT : OP_TAKE_WHOLE;
              state_nxt = sts.can_split ? S_TAKE : S_RESP;
            end else if (sts.nxt_ok_hdr) begin
              ctl.op    = OP_ADV;
              state_nxt = S_RD;
            end else begin
              ctl.op    = OP_NOFIT;
              state_nxt = S_RESP;
            end
          end
          CMD_FREE: begin
            if (sts.match) begin
              ctl.op    = sts.merge_en ? OP_AB_START : OP_FREE_WR;
              state_nxt = sts.merge_en ? S_AB_CHK : S_RESP;
            end else if (sts.nxt_ok_hdr) begin
              ctl.op    = OP_ADV;
              state_nxt = S_RD;
            end else begin
              state_nxt = S_RESP;
            end
          end
          CMD_DEFRAG: begin
            if (!sts.hdr_used) begin
              ctl.op    = OP_AB_START;
              state_nxt = S_AB_CHK;
            end else if (sts.nxt_ok_hdr) begin
              ctl.op    = OP_ADV;
              state_nxt = S_RD;
            end else begin
              ctl.op    = OP_DONE;
              state_nxt = S_RESP;
            end
          end
          default: begin
            ctl.op    = OP_ACC;
            state_nxt = sts.nxt_ok_hdr ? S_RD : S_DIV1;
          end
        endcase
      end
      S_TAKE: begin
        ctl.op    = OP_TAKE_SIZE;
        state_nxt = S_RESP;
      end
      S_AB_CHK: begin
        if (sts.nxt_ok_cur) begin
          ctl.op    = OP_READ_NXT;
          state_nxt = S_AB_EV;
        end else begin
          ctl.op    = OP_AB_WRITE;
          state_nxt = S_AB_END;
        end
      end
      S_AB_EV: begin
        if (sts.hdr_used) begin
          ctl.op    = OP_AB_WRITE;
          state_nxt = S_AB_END;
        end else begin
          ctl.op    = OP_AB_ADD;
          state_nxt = S_AB_CHK;
        end
      end
      S_AB_END: begin
        // Defragment resumes the walk after the merged entry
        if (sts.cmd == CMD_DEFRAG && sts.nxt_ok_cur) begin
          ctl.op    = OP_ADV_CUR;
          state_nxt = S_RD;
        end else begin
          ctl.op    = OP_DONE;
          state_nxt = S_RESP;
        end
      end
      S_DIV1: begin
        ctl.op    = OP_DIV_USED;
        state_nxt = S_DW1;
      end
      S_DW1: begin
        if (sts.div_done) begin
          ctl.op    = OP_UPCT;
          state_nxt = sts.ft_nz ? S_DIV2 : S_RESP;
        end
      end
      S_DIV2: begin
        ctl.op    = OP_DIV_FRAG;
        state_nxt = S_DW2;
      end
      S_DW2: begin
        if (sts.div_done) begin
          ctl.op    = OP_FPCT;
          state_nxt = S_RESP;
        end
      end
      S_RESP: begin
        // Publish once the output register is free
        if (!out_valid_r || out_ready) begin
          ctl.publish = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    if (ctl.publish) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  // Never overwrite a result still waiting for transfer
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.publish |-> (!out_valid_r || out_ready))
    else $error("result overwritten before transfer");

  // Merging only happens for free and defragment
  a_merge_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_AB_CHK) |-> (sts.cmd == CMD_FREE || sts.cmd == CMD_DEFRAG))
    else $error("merge entered for wrong command");

  // An accepted command is decoded next cycle
  a_accept_dec: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_DEC))
    else $error("accepted command not decoded");

endmodule

// ===== design/first_fit_heap_allocator.sv =====
// Top level of the first-fit heap allocator: controller, datapath and divider.
//
//   port     | dir | contents
//   ---------+-----+------------------------------------------------------
//   in_ch    | in  | command, pool, request size, freed handle
//   out_ch   | out | status, data offset, token flag, monitor statistics
//   cfg_*    | in  | pool sizes, alignment, merge-on-free
//
// Alloc, free, defragment and monitor walk the entry chain through the single header
// memory port, and a merge also reads each entry that it absorbs; monitor adds up to
// two divisions. Init and ignored commands do not walk the chain.
// Reset clears the pools' ready flags; headers are written by init.
// A result waits in the output register while the next command is accepted.
`timescale 1ns / 1ps
module first_fit_heap_allocator #(
  parameter int POOL_BYTES   = ffha_pkg::POOL_BYTES_DEF,
  parameter int HEADER_BYTES = ffha_pkg::HEADER_BYTES_DEF,
  parameter int POOL_COUNT   = ffha_pkg::POOL_COUNT_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  ffha_in_if.sink                        in_ch,
  ffha_out_if.source                     out_ch,
  input  logic                           cfg_we,
  input  logic [ffha_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ffha_pkg::CFG_W-1:0]     cfg_data
);
  import ffha_pkg::*;

  localparam int SZW = $clog2(POOL_BYTES + 1);
  localparam int DSW = SZW + 2;
  localparam int DVW = DSW + 7;

  in_item_t       in_item;
  res_item_t      res;
  ctl_cmd_t       ctl;
  dp_sts_t        sts;
  logic           div_start, div_done;
  logic [DVW-1:0] div_dividend, div_quotient;
  logic [DSW-1:0] div_divisor;

  assign in_item = '{command:       in_ch.command,
                     pool_index:    in_ch.pool_index,
                     request_size:  in_ch.request_size,
                     free_offset:   in_ch.free_offset,
                     free_is_token: in_ch.free_is_token,
                     free_is_null:  in_ch.free_is_null};

  ffha_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .ctl       (ctl)
  );

  ffha_dp #(
    .POOL_BYTES   (POOL_BYTES),
    .HEADER_BYTES (HEADER_BYTES),
    .POOL_COUNT   (POOL_COUNT),
    .DVW          (DVW),
    .DSW          (DSW)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_item      (in_item),
    .ctl          (ctl),
    .sts          (sts),
    .res          (res),
    .div_start    (div_start),
    .div_dividend (div_dividend),
    .div_divisor  (div_divisor),
    .div_done     (div_done),
    .div_quotient (div_quotient)
  );

  ffha_div #(
    .DVW (DVW),
    .DSW (DSW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quotient)
  );

  // Drive the result payload
  assign out_ch.status       = res.status;
  assign out_ch.data_offset  = res.data_offset;
  assign out_ch.zero_token   = res.zero_token;
  assign out_ch.free_count   = res.free_count;
  assign out_ch.used_count   = res.used_count;
  assign out_ch.free_total   = res.free_total;
  assign out_ch.free_largest = res.free_largest;
  assign out_ch.used_percent = res.used_percent;
  assign out_ch.frag_percent = res.frag_percent;

endmodule

// ===== test/tb.sv =====
// Self-checking testbench of the first-fit heap allocator: directed and random commands.
`timescale 1ns / 1ps
module tb;
  import ffha_pkg::*;

  localparam int  PBYTES     = POOL_BYTES_DEF;
  localparam int  HBYTES     = HEADER_BYTES_DEF;
  localparam int  WORDS      = PBYTES / 4;
  localparam int  LATENCY    = 200;
  localparam longint LIMIT   = 40_000_000;
  localparam logic [31:0] USED_FLAG = 32'h8000_0000;
  localparam logic [31:0] SIZE_BITS = 32'h7FFF_FFFF;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  ffha_in_if  in_ch ();
  ffha_out_if out_ch ();

  first_fit_heap_allocator u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Mirror of the allocator state
  logic [31:0] hdr_mirror [0:2*WORDS-1];
  int unsigned pool_len [2];
  bit          pool_live [2];
  int unsigned size_reg [2];
  bit          align8_reg;
  bit          merge_reg;

  res_item_t   expected_q [$];
  int unsigned handles [2][$];
  int          errors;
  longint      cycles;
  bit          idle_on;

  // Start low so that the first rising edge comes after time zero
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("** first_fit_heap_allocator: FAILED **");
      $finish;
    end
  end

  function automatic int unsigned widx(int unsigned p, int unsigned off);
    return p * WORDS + ((off >> 2) % WORDS);
  endfunction

  // Offset of the following entry; false at the end of the chain
  function automatic bit next_of(int unsigned p, int unsigned off, output int unsigned nxt);
    nxt = off + HBYTES + (hdr_mirror[widx(p, off)] & SIZE_BITS);
    return (nxt + HBYTES) < pool_len[p];
  endfunction

  function automatic void merge_after(int unsigned p, int unsigned off);
    int unsigned nxt;
    logic [31:0] h;
    logic [31:0] nh;
    while (next_of(p, off, nxt)) begin
      nh = hdr_mirror[widx(p, nxt)];
      h  = hdr_mirror[widx(p, off)];
      if (nh & USED_FLAG) break;
      hdr_mirror[widx(p, off)] = (h & USED_FLAG) |
        (((h & SIZE_BITS) + (nh & SIZE_BITS) + HBYTES) & SIZE_BITS);
    end
  endfunction

  // Compute the result of one command and advance the mirror
  function automatic res_item_t allocator_result(in_item_t it);
    res_item_t r;
    int unsigned p, off, nxt, t, sz, d, mask;
    int unsigned fc, uc, ft, fl, upct, fpct;
    logic [31:0] h;
    r = '0;
    r.status = ST_IGNORED;
    p = it.pool_index;
    if (it.command == CMD_ALLOC && it.request_size == 0) begin
      r.status = ST_DONE;
      r.zero_token = 1'b1;
      return r;
    end
    if (it.command > CMD_MONITOR) return r;
    if (it.command == CMD_INIT) begin
      t = size_reg[p];
      if (t > PBYTES) t = PBYTES;
      if (t < HBYTES) t = HBYTES;
      pool_len[p] = t;
      pool_live[p] = 1'b1;
      hdr_mirror[widx(p, 0)] = (t - HBYTES) & SIZE_BITS;
      r.status = ST_DONE;
      return r;
    end
    if (!pool_live[p]) return r;
    off = 0;
    case (it.command)
      CMD_ALLOC: begin
        mask = align8_reg ? 7 : 3;
        sz = it.request_size;
        if (sz & mask) sz = (sz & ~mask) + mask + 1;
        forever begin
          h = hdr_mirror[widx(p, off)];
          d = h & SIZE_BITS;
          if (!(h & USED_FLAG) && d >= sz) begin
            // split only when the remainder holds more than a header
            if (d - sz > HBYTES) begin
              hdr_mirror[widx(p, off + HBYTES + sz)] = (d - sz - HBYTES) & SIZE_BITS;
              d = sz;
            end
            hdr_mirror[widx(p, off)] = USED_FLAG | d;
            r.status = ST_DONE;
            r.data_offset = FOFF_W'(off + HBYTES);
            return r;
          end
          if (!next_of(p, off, nxt)) break;
          off = nxt;
        end
        r.status = ST_NOFIT;
      end
      CMD_FREE: begin
        if (it.free_is_token || it.free_is_null) return r;
        forever begin
          if (off + HBYTES == it.free_offset) begin
            hdr_mirror[widx(p, off)] &= SIZE_BITS;
            if (merge_reg) merge_after(p, off);
            r.status = ST_DONE;
            return r;
          end
          if (!next_of(p, off, nxt)) return r;
          off = nxt;
        end
      end
      CMD_DEFRAG: begin
        forever begin
          if (!(hdr_mirror[widx(p, off)] & USED_FLAG)) merge_after(p, off);
          if (!next_of(p, off, nxt)) break;
          off = nxt;
        end
        r.status = ST_DONE;
      end
      default: begin
        fc = 0; uc = 0; ft = 0; fl = 0; fpct = 0;
        forever begin
          h = hdr_mirror[widx(p, off)];
          if (h & USED_FLAG) uc++;
          else begin
            fc++;
            ft += h & SIZE_BITS;
            if ((h & SIZE_BITS) > fl) fl = h & SIZE_BITS;
          end
          if (!next_of(p, off, nxt)) break;
          off = nxt;
        end
        upct = 100 - (100 * ft) / pool_len[p];
        if (ft != 0) fpct = 100 - (fl * 100) / ft;
        r.status = ST_DONE;
        r.free_count = CNT_W'(fc);
        r.used_count = CNT_W'(uc);
        r.free_total = TOT_W'(ft);
        r.free_largest = TOT_W'(fl);
        r.used_percent = PCT_W'(upct);
        r.frag_percent = PCT_W'(fpct);
      end
    endcase
    return r;
  endfunction

  function automatic in_item_t mk(logic [CMD_W-1:0] c, bit p, int unsigned req,
                                  int unsigned off, bit tok, bit nul);
    in_item_t it;
    it.command = c;
    it.pool_index = p;
    it.request_size = REQ_W'(req);
    it.free_offset = FOFF_W'(off);
    it.free_is_token = tok;
    it.free_is_null = nul;
    return it;
  endfunction

  task automatic report_mismatch(string field, int got, int want);
    $display("mismatch in %s: got %0d, expected %0d", field, got, want);
    errors++;
  endtask

  // Offer one command and hold it until the transfer
  task automatic send_cmd(in_item_t it);
    int gap;
    res_item_t r;
    gap = idle_on ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.command <= it.command;
    in_ch.pool_index <= it.pool_index;
    in_ch.request_size <= it.request_size;
    in_ch.free_offset <= it.free_offset;
    in_ch.free_is_token <= it.free_is_token;
    in_ch.free_is_null <= it.free_is_null;
    do @(posedge clk); while (!in_ch.ready);
    r = allocator_result(it);
    expected_q.push_back(r);
    if (it.command == CMD_INIT) handles[it.pool_index].delete();
    else if (it.command == CMD_ALLOC && r.status == ST_DONE && !r.zero_token)
      handles[it.pool_index].push_back(r.data_offset);
  endtask

  // Hold off until every result is back, then let the block settle
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_W'(val);
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_POOL0_BYTES: size_reg[0] = val & 32'h7FFF;
      REG_POOL1_BYTES: size_reg[1] = val & 32'h7FFF;
      REG_ALIGN_EIGHT: align8_reg = val & 1;
      default:         merge_reg = val & 1;
    endcase
  endtask

  task automatic set_config(int unsigned b0, int unsigned b1, bit a8, bit mg);
    drain();
    write_reg(REG_POOL0_BYTES, b0);
    write_reg(REG_POOL1_BYTES, b1);
    write_reg(REG_ALIGN_EIGHT, a8);
    write_reg(REG_MERGE_ON_FREE, mg);
  endtask

  // Result side: random stall, then check the transfer
  initial begin
    int stall;
    res_item_t want;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = idle_on ? $urandom_range(0, 5) : 0;
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      if (expected_q.size() == 0) begin
        $display("result with nothing expected");
        errors++;
      end else begin
        want = expected_q.pop_front();
        if (out_ch.status !== want.status)
          report_mismatch("status", out_ch.status, want.status);
        if (out_ch.data_offset !== want.data_offset)
          report_mismatch("data_offset", out_ch.data_offset, want.data_offset);
        if (out_ch.zero_token !== want.zero_token)
          report_mismatch("zero_token", out_ch.zero_token, want.zero_token);
        if (out_ch.free_count !== want.free_count)
          report_mismatch("free_count", out_ch.free_count, want.free_count);
        if (out_ch.used_count !== want.used_count)
          report_mismatch("used_count", out_ch.used_count, want.used_count);
        if (out_ch.free_total !== want.free_total)
          report_mismatch("free_total", out_ch.free_total, want.free_total);
        if (out_ch.free_largest !== want.free_largest)
          report_mismatch("free_largest", out_ch.free_largest, want.free_largest);
        if (out_ch.used_percent !== want.used_percent)
          report_mismatch("used_percent", out_ch.used_percent, want.used_percent);
        if (out_ch.frag_percent !== want.frag_percent)
          report_mismatch("frag_percent", out_ch.frag_percent, want.frag_percent);
      end
    end
  end

  // Commands to pools that were never initialised, zero sizes, unknown codes
  task automatic test_unready();
    send_cmd(mk(CMD_ALLOC, 0, 16, 0, 0, 0));
    send_cmd(mk(CMD_MONITOR, 1, 0, 0, 0, 0));
    send_cmd(mk(CMD_FREE, 0, 0, 4, 0, 0));
    send_cmd(mk(CMD_DEFRAG, 1, 0, 0, 0, 0));
    send_cmd(mk(CMD_ALLOC, 1, 0, 0, 0, 0));
    send_cmd(mk(3'd5, 0, 0, 0, 0, 0));
    send_cmd(mk(3'd6, 1, 0, 0, 0, 0));
    send_cmd(mk(3'd7, 0, 32767, 16383, 1, 1));
  endtask

  // Rounding, no fit, odd handles, double free, a full pool
  task automatic test_pool_ops();
    send_cmd(mk(CMD_INIT, 0, 0, 0, 0, 0));
    send_cmd(mk(CMD_INIT, 1, 0, 0, 0, 0));
    send_cmd(mk(CMD_ALLOC, 0, 1, 0, 0, 0));
    send_cmd(mk(CMD_ALLOC, 0, 5, 0, 0, 0));
    send_cmd(mk(CMD_ALLOC, 1, 32767, 0, 0, 0));
    send_cmd(mk(CMD_FREE, 0, 0, 4, 1, 0));
    send_cmd(mk(CMD_FREE, 0, 0, 4, 0, 1));
    send_cmd(mk(CMD_FREE, 0, 0, 16383, 0, 0));
    send_cmd(mk(CMD_FREE, 0, 0, 4, 0, 0));
    send_cmd(mk(CMD_FREE, 0, 0, 4, 0, 0));
    send_cmd(mk(CMD_MONITOR, 0, 0, 0, 0, 0));
    send_cmd(mk(CMD_DEFRAG, 0, 0, 0, 0, 0));
    send_cmd(mk(CMD_ALLOC, 1, 16380, 0, 0, 0));
    send_cmd(mk(CMD_MONITOR, 1, 0, 0, 0, 0));
    send_cmd(mk(CMD_FREE, 1, 0, 4, 0, 0));
    send_cmd(mk(CMD_MONITOR, 1, 0, 0, 0, 0));
    handles[0].delete();
    handles[1].delete();
  endtask

  // Mostly well-formed allocate/free traffic with some noise
  task automatic test_random(int unsigned b0, int unsigned b1, bit a8, bit mg, int n);
    int k, sel, i;
    bit p;
    int unsigned sz;
    set_config(b0, b1, a8, mg);
    send_cmd(mk(CMD_INIT, 0, 0, 0, 0, 0));
    send_cmd(mk(CMD_INIT, 1, 0, 0, 0, 0));
    for (k = 0; k < n; k++) begin
      if (k % 50 == 0) idle_on = ($urandom_range(0, 3) != 0);
      p = 1'($urandom_range(0, 1));
      sel = $urandom_range(0, 99);
      if (sel < 60 && sel >= 30 && handles[p].size() != 0) begin
        i = $urandom_range(0, handles[p].size() - 1);
        send_cmd(mk(CMD_FREE, p, 0, handles[p][i], 0, 0));
        // keep an occasional stale handle for a second free
        if ($urandom_range(0, 9) != 0) handles[p].delete(i);
      end else if (sel < 60) begin
        sel = $urandom_range(0, 99);
        if (sel < 85) sz = $urandom_range(1, 200);
        else if (sel < 97) sz = $urandom_range(0, 4096);
        else sz = $urandom_range(0, 32767);
        send_cmd(mk(CMD_ALLOC, p, sz, 0, 0, 0));
      end else if (sel < 67) begin
        send_cmd(mk(CMD_FREE, p, 0, $urandom_range(0, 16383),
                    $urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0));
      end else if (sel < 75) begin
        send_cmd(mk(CMD_DEFRAG, p, 0, 0, 0, 0));
      end else if (sel < 89) begin
        send_cmd(mk(CMD_MONITOR, p, 0, 0, 0, 0));
      end else if (sel < 93) begin
        send_cmd(mk(CMD_INIT, p, 0, 0, 0, 0));
      end else begin
        send_cmd(mk(CMD_W'($urandom_range(0, 7)), p, $urandom_range(0, 32767),
                    $urandom_range(0, 16383), 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1))));
      end
    end
  endtask

  initial begin
    errors = 0;
    cycles = 0;
    idle_on = 1'b1;
    pool_len = '{0, 0};
    pool_live = '{0, 0};
    size_reg = '{16384, 16384};
    align8_reg = 1'b0;
    merge_reg = 1'b1;
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    in_ch.valid <= 1'b0;
    in_ch.command <= '0;
    in_ch.pool_index <= 1'b0;
    in_ch.request_size <= '0;
    in_ch.free_offset <= '0;
    in_ch.free_is_token <= 1'b0;
    in_ch.free_is_null <= 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_unready();
    test_pool_ops();
    test_random(16384, 16384, 0, 1, 300);
    test_random(8, 2, 1, 0, 120);
    test_random(32767, 0, 0, 0, 150);
    test_random(2000, 601, 1, 1, 280);
    test_random(16384, 16384, 1, 0, 150);

    drain();
    if (errors == 0) begin
      $display("** first_fit_heap_allocator: PASSED **");
    end else begin
      $display("** first_fit_heap_allocator: FAILED **");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/ffha_pkg.sv
design/ffha_if.sv
design/ffha_div.sv
design/ffha_dp.sv
design/ffha_ctrl.sv
design/first_fit_heap_allocator.sv
test/tb.sv
